// ===== hdl/best_fit_page_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit page allocator
// Clocked on clk and disabled during rst of the including module.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_PAGE_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BFPA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfpa: same-cycle check failed");

// next-cycle implication
`define BFPA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfpa: next-cycle check failed");

`endif

// ===== hdl/bfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared widths, codes, types and mask helpers of the page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfpa_pkg;

  localparam int ADDR_BITS   = 20;
  localparam int MAX_EXTENTS = 32;
  localparam int LEN_W       = ADDR_BITS + 1;
  localparam int SUM_W       = ADDR_BITS + 2;
  localparam int MRG_W       = ADDR_BITS + 3;

  localparam logic [LEN_W-1:0] SUM_MAX = {1'b1, {ADDR_BITS{1'b0}}};
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef logic [MAX_EXTENTS-1:0] ext_mask_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0]     len;
  } entry_t;

  localparam int ENTRY_W = 1 + ADDR_BITS + LEN_W;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [LEN_W-1:0]     n;
    logic [SUM_W-1:0]     base_plus_n;
    logic [ADDR_BITS-1:0] ins_start;
    logic [LEN_W-1:0]     ins_len;
  } query_t;

  typedef struct packed {
    logic fit;
    logic lo;
    logic hi;
    logic ins;
  } flags_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LOW,
    CELL_FROM_HIGH,
    CELL_LOAD
  } cell_op_t;

  typedef enum logic [1:0] {
    CH_HOLD,
    CH_REMOVE,
    CH_INSERT
  } chain_cmd_t;

  function automatic ext_mask_t first_one(ext_mask_t v);
    return v & (~v + 1'b1);
  endfunction

  function automatic ext_mask_t at_or_after(ext_mask_t first);
    return ~(first - 1'b1);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bfpa_req_if.sv =====
// ----------------------------------------------------------------------------
// bfpa_req_if
// Request channel: opcode, base page and page count with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfpa_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     opcode;
  logic [bfpa_pkg::ADDR_BITS-1:0] base_page;
  logic [bfpa_pkg::LEN_W-1:0]     page_count;

  modport source (output valid, output opcode, output base_page, output page_count,
                  input ready);
  modport sink (input valid, input opcode, input base_page, input page_count,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/bfpa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bfpa_rsp_if
// Response channel: status, allocated base and free total with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfpa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [bfpa_pkg::ADDR_BITS-1:0] alloc_base;
  logic [bfpa_pkg::LEN_W-1:0]     free_total;

  modport source (output valid, output status, output alloc_base, output free_total,
                  input ready);
  modport sink (input valid, input status, input alloc_base, input free_total,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/bfpa_cell.sv =====
// ----------------------------------------------------------------------------
// bfpa_cell
// One extent slot: holds start/length/valid, matches against the query and
// takes data from its lower or higher neighbor when the table shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module bfpa_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  bfpa_pkg::cell_op_t   op,
  input  bfpa_pkg::entry_t     from_low,
  input  bfpa_pkg::entry_t     from_high,
  input  bfpa_pkg::query_t     q,
  output bfpa_pkg::entry_t     entry,
  output bfpa_pkg::flags_t     flags
);

  logic [bfpa_pkg::SUM_W-1:0] end_page;

  assign end_page = {2'b00, entry.start} + {1'b0, entry.len};

  always_comb begin
    flags.fit = entry.valid && (entry.len >= q.n);
    flags.lo  = entry.valid && (entry.start < q.base) &&
                (end_page == {2'b00, q.base});
    flags.hi  = entry.valid && ({2'b00, entry.start} == q.base_plus_n);
    flags.ins = !entry.valid || (q.ins_len <= entry.len);
  end

  always_ff @(posedge clk) begin
    case (op)
      bfpa_pkg::CELL_FROM_LOW:  entry <= from_low;
      bfpa_pkg::CELL_FROM_HIGH: entry <= from_high;
      bfpa_pkg::CELL_LOAD: begin
        entry.valid <= 1'b1;
        entry.start <= q.ins_start;
        entry.len   <= q.ins_len;
      end
      default: entry <= entry;
    endcase
    if (rst) begin
      entry.valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bfpa_chain.sv =====
// ----------------------------------------------------------------------------
// bfpa_chain
// Row of extent cells kept packed and sorted by length; removes at a marked
// slot or inserts at the first slot of equal or greater length.
// ----------------------------------------------------------------------------
`default_nettype none

module bfpa_chain (
  input  wire                    clk,
  input  wire                    rst,
  input  bfpa_pkg::chain_cmd_t   cmd,
  input  bfpa_pkg::ext_mask_t    rm_mask,
  input  bfpa_pkg::query_t       q,
  output bfpa_pkg::ext_mask_t    fit_first,
  output bfpa_pkg::ext_mask_t    lo_first,
  output bfpa_pkg::ext_mask_t    hi_first,
  output bfpa_pkg::entry_t       fit_e,
  output bfpa_pkg::entry_t       lo_e,
  output bfpa_pkg::entry_t       hi_e,
  output bfpa_pkg::ext_mask_t    valid_v,
  output logic                   full
);

  localparam int N = bfpa_pkg::MAX_EXTENTS;

  bfpa_pkg::entry_t    e        [N];
  bfpa_pkg::entry_t    low_in   [N];
  bfpa_pkg::entry_t    high_in  [N];
  bfpa_pkg::flags_t    f        [N];
  bfpa_pkg::cell_op_t  cop      [N];
  bfpa_pkg::ext_mask_t fit_v, lo_v, hi_v, ins_v;
  bfpa_pkg::ext_mask_t ins_first, ins_after, rem_from;
  logic [bfpa_pkg::ENTRY_W-1:0] fit_acc, lo_acc, hi_acc;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign low_in[i] = '0;
    end else begin : g_mid_lo
      assign low_in[i] = e[i-1];
    end
    if (i == N - 1) begin : g_last
      assign high_in[i] = '0;
    end else begin : g_mid_hi
      assign high_in[i] = e[i+1];
    end

    assign fit_v[i]   = f[i].fit;
    assign lo_v[i]    = f[i].lo;
    assign hi_v[i]    = f[i].hi;
    assign ins_v[i]   = f[i].ins;
    assign valid_v[i] = e[i].valid;

    bfpa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (cop[i]),
      .from_low  (low_in[i]),
      .from_high (high_in[i]),
      .q         (q),
      .entry     (e[i]),
      .flags     (f[i])
    );
  end

  assign fit_first = bfpa_pkg::first_one(fit_v);
  assign lo_first  = bfpa_pkg::first_one(lo_v);
  assign hi_first  = bfpa_pkg::first_one(hi_v);
  assign ins_first = bfpa_pkg::first_one(ins_v);
  assign ins_after = bfpa_pkg::at_or_after(ins_first) & ~ins_first;
  assign rem_from  = bfpa_pkg::at_or_after(rm_mask);
  assign full      = e[N-1].valid;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      case (cmd)
        bfpa_pkg::CH_REMOVE:
          cop[i] = rem_from[i] ? bfpa_pkg::CELL_FROM_HIGH : bfpa_pkg::CELL_HOLD;
        bfpa_pkg::CH_INSERT:
          cop[i] = ins_first[i] ? bfpa_pkg::CELL_LOAD :
                   ins_after[i] ? bfpa_pkg::CELL_FROM_LOW : bfpa_pkg::CELL_HOLD;
        default:
          cop[i] = bfpa_pkg::CELL_HOLD;
      endcase
    end
  end

  always_comb begin
    fit_acc = '0;
    lo_acc  = '0;
    hi_acc  = '0;
    for (int i = 0; i < N; i++) begin
      fit_acc = fit_acc | (e[i] & {bfpa_pkg::ENTRY_W{fit_first[i]}});
      lo_acc  = lo_acc  | (e[i] & {bfpa_pkg::ENTRY_W{lo_first[i]}});
      hi_acc  = hi_acc  | (e[i] & {bfpa_pkg::ENTRY_W{hi_first[i]}});
    end
  end

  assign fit_e = bfpa_pkg::entry_t'(fit_acc);
  assign lo_e  = bfpa_pkg::entry_t'(lo_acc);
  assign hi_e  = bfpa_pkg::entry_t'(hi_acc);

endmodule

`default_nettype wire

// ===== hdl/best_fit_page_allocator.sv =====
// ----------------------------------------------------------------------------
// best_fit_page_allocator
// Best-fit page allocator over a length-sorted table of free extents.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns exactly one response per
// item. An item that is refused or does nothing (zero count, unused opcode,
// no space, table full) goes from evaluation straight to the response state;
// an add passes through an insert, an allocate through a removal and, if a
// remainder is put back, an insert, and a free through a removal for each
// merged neighbor and then an insert. Once the response is loaded, the next
// item is taken. The extent table is a row of 32 cells that does one search,
// one removal or one sorted insert per cycle. A finished response sits in an
// output register, so a new item is taken while it waits to be read; a second
// response waits until the first one is gone. Reset empties the table at once.
`default_nettype none

`include "best_fit_page_allocator_defines.svh"

module best_fit_page_allocator (
  input wire        clk,
  input wire        rst,
  bfpa_req_if.sink  req,
  bfpa_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_REM_A,
    S_REM_B,
    S_INS,
    S_RESP
  } state_t;

  state_t                         state;
  logic [1:0]                     op;
  logic [bfpa_pkg::ADDR_BITS-1:0] base;
  logic [bfpa_pkg::LEN_W-1:0]     n;
  logic [bfpa_pkg::LEN_W-1:0]     sum;
  logic [1:0]                     status;
  logic [bfpa_pkg::ADDR_BITS-1:0] abase;
  logic [bfpa_pkg::ADDR_BITS-1:0] sel_start;
  logic [bfpa_pkg::LEN_W-1:0]     sel_len;
  logic [bfpa_pkg::LEN_W-1:0]     hi_len;
  bfpa_pkg::ext_mask_t            rm_a;
  bfpa_pkg::ext_mask_t            rm_b;
  logic [bfpa_pkg::ADDR_BITS-1:0] ins_start;
  logic [bfpa_pkg::LEN_W-1:0]     ins_len;
  logic                           rsp_valid;
  logic [1:0]                     rsp_status;
  logic [bfpa_pkg::ADDR_BITS-1:0] rsp_base;
  logic [bfpa_pkg::LEN_W-1:0]     rsp_total;

  bfpa_pkg::chain_cmd_t           cmd;
  bfpa_pkg::ext_mask_t            rm_mask;
  bfpa_pkg::query_t               q;
  bfpa_pkg::ext_mask_t            fit_first, lo_first, hi_first, valid_v;
  bfpa_pkg::entry_t               fit_e, lo_e, hi_e;
  logic                           full;

  logic [bfpa_pkg::LEN_W:0]       sum_wide;
  logic [bfpa_pkg::LEN_W-1:0]     sum_add;
  logic [bfpa_pkg::MRG_W-1:0]     merge_wide;
  logic [bfpa_pkg::LEN_W-1:0]     merge_len;
  logic                           lo_found, hi_found;

  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.alloc_base = rsp_base;
  assign rsp.free_total = rsp_total;

  always_comb begin
    sum_wide = {1'b0, sum} + {1'b0, n};
    sum_add  = (sum_wide > {1'b0, bfpa_pkg::SUM_MAX}) ? bfpa_pkg::SUM_MAX
                                                      : sum_wide[bfpa_pkg::LEN_W-1:0];
    merge_wide = {2'b00, sel_len} + {2'b00, n} + {2'b00, hi_len};
    merge_len  = (merge_wide > {2'b00, bfpa_pkg::LEN_MAX}) ? bfpa_pkg::LEN_MAX
                                                           : merge_wide[bfpa_pkg::LEN_W-1:0];
    lo_found = (lo_first != '0);
    hi_found = (hi_first != '0);
  end

  always_comb begin
    q.base        = base;
    q.n           = n;
    q.base_plus_n = {2'b00, base} + {1'b0, n};
    q.ins_start   = ins_start;
    q.ins_len     = ins_len;
    case (state)
      S_REM_A: begin
        cmd     = bfpa_pkg::CH_REMOVE;
        rm_mask = rm_a;
      end
      S_REM_B: begin
        cmd     = bfpa_pkg::CH_REMOVE;
        rm_mask = rm_b;
      end
      S_INS: begin
        cmd     = bfpa_pkg::CH_INSERT;
        rm_mask = '0;
      end
      default: begin
        cmd     = bfpa_pkg::CH_HOLD;
        rm_mask = '0;
      end
    endcase
  end

  bfpa_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rm_mask   (rm_mask),
    .q         (q),
    .fit_first (fit_first),
    .lo_first  (lo_first),
    .hi_first  (hi_first),
    .fit_e     (fit_e),
    .lo_e      (lo_e),
    .hi_e      (hi_e),
    .valid_v   (valid_v),
    .full      (full)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sum       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op     <= req.opcode;
            base   <= req.base_page;
            n      <= req.page_count;
            status <= bfpa_pkg::ST_OK;
            abase  <= '0;
            state  <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_RESP;
          case (op)
            bfpa_pkg::OP_ADD: begin
              if (n != '0) begin
                if (full) begin
                  status <= bfpa_pkg::ST_FULL;
                end else begin
                  ins_start <= base;
                  ins_len   <= n;
                  sum       <= sum_add;
                  state     <= S_INS;
                end
              end
            end
            bfpa_pkg::OP_ALLOC: begin
              if (n == '0 || n > sum || fit_first == '0) begin
                status <= bfpa_pkg::ST_NO_SPACE;
              end else begin
                sel_start <= fit_e.start;
                sel_len   <= fit_e.len;
                abase     <= fit_e.start;
                rm_a      <= fit_first;
                rm_b      <= '0;
                sum       <= sum - n;
                state     <= S_REM_A;
              end
            end
            bfpa_pkg::OP_FREE: begin
              if (n != '0) begin
                if (!lo_found && !hi_found && full) begin
                  status <= bfpa_pkg::ST_FULL;
                end else begin
                  sel_start <= lo_found ? lo_e.start : base;
                  sel_len   <= lo_found ? lo_e.len : '0;
                  hi_len    <= hi_found ? hi_e.len : '0;
                  sum       <= sum_add;
                  if (!lo_found && !hi_found) begin
                    ins_start <= base;
                    ins_len   <= n;
                    state     <= S_INS;
                  end else begin
                    rm_a  <= (lo_first > hi_first) ? lo_first : hi_first;
                    rm_b  <= (lo_first > hi_first) ? hi_first : lo_first;
                    state <= S_REM_A;
                  end
                end
              end
            end
            default: state <= S_RESP;
          endcase
        end
        S_REM_A: begin
          if (op == bfpa_pkg::OP_ALLOC) begin
            ins_start <= bfpa_pkg::ADDR_BITS'({1'b0, sel_start} + n);
            ins_len   <= sel_len - n;
            state     <= (sel_len > n) ? S_INS : S_RESP;
          end else begin
            ins_start <= sel_start;
            ins_len   <= merge_len;
            state     <= (rm_b != '0) ? S_REM_B : S_INS;
          end
        end
        S_REM_B: begin
          state <= S_INS;
        end
        S_INS: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= status;
            rsp_base   <= abase;
            rsp_total  <= sum;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BFPA_ASSERT_IMPL(a_table_packed, 1'b1, (valid_v & (valid_v + 1'b1)) == '0)
  `BFPA_ASSERT_IMPL(a_insert_has_room, state == S_INS, !full)
  `BFPA_ASSERT_IMPL(a_sum_bounded, 1'b1, sum <= bfpa_pkg::SUM_MAX)
  `BFPA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)

endmodule

`default_nettype wire

// ===== dv/best_fit_page_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// best_fit_page_allocator_tb
// Self-checking bench for the best-fit page allocator. A queue of requests
// feeds a clocked driver; a monitor predicts each response from a shadow
// extent table and compares it field by field. A directed opening covers
// zero counts, wrapped remainders, merges on both sides, saturation and
// exact fits. Random episodes then carve regions, free them back and fill
// the table under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_page_allocator_tb;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         PRED        = 0;
  localparam int         PLAN        = 1;
  localparam int         HOLD_CYCLES = 300;
  localparam int         CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]                     opcode;
    logic [bfpa_pkg::ADDR_BITS-1:0] base_page;
    logic [bfpa_pkg::LEN_W-1:0]     page_count;
  } page_req_t;

  typedef struct packed {
    logic [1:0]                     status;
    logic [bfpa_pkg::ADDR_BITS-1:0] alloc_base;
    logic [bfpa_pkg::LEN_W-1:0]     free_total;
  } page_rsp_t;

  typedef struct packed {
    logic [bfpa_pkg::ADDR_BITS-1:0] base;
    logic [bfpa_pkg::LEN_W-1:0]     count;
  } page_block_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           req_valid = 1'b0;
  logic [1:0]                     req_opcode = bfpa_pkg::OP_ADD;
  logic [bfpa_pkg::ADDR_BITS-1:0] req_base = '0;
  logic [bfpa_pkg::LEN_W-1:0]     req_count = '0;
  logic                           rsp_ready = 1'b0;

  bfpa_req_if req();
  bfpa_rsp_if rsp();

  assign req.valid      = req_valid;
  assign req.opcode     = req_opcode;
  assign req.base_page  = req_base;
  assign req.page_count = req_count;
  assign rsp.ready      = rsp_ready;

  best_fit_page_allocator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow extent tables: one for checking, one for planning stimulus
  logic [bfpa_pkg::ADDR_BITS-1:0] tbl_start [2][bfpa_pkg::MAX_EXTENTS];
  logic [bfpa_pkg::LEN_W-1:0]     tbl_len   [2][bfpa_pkg::MAX_EXTENTS];
  int                             tbl_used  [2];
  logic [bfpa_pkg::LEN_W-1:0]     tbl_free  [2];

  page_req_t   pending_reqs[$];
  page_rsp_t   expected_rsps[$];
  page_block_t held_blocks[$];

  page_req_t next_req;
  page_req_t seen_req;
  page_rsp_t want_rsp;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_armed = 1'b0;
  int  hold_count = 0;
  bit  req_accepted = 1'b0;
  int  issued_count = 0;
  int  checked_count = 0;
  int  stim_count = 0;
  int  err_count = 0;
  int  cycle_count = 0;

  function automatic void tbl_clear(int m);
    tbl_used[m] = 0;
    tbl_free[m] = '0;
  endfunction

  function automatic void tbl_remove(int m, int pos);
    int i;
    for (i = pos; i + 1 < tbl_used[m]; i++) begin
      tbl_start[m][i] = tbl_start[m][i+1];
      tbl_len[m][i]   = tbl_len[m][i+1];
    end
    tbl_used[m]--;
  endfunction

  function automatic void tbl_insert(int m, logic [bfpa_pkg::ADDR_BITS-1:0] s,
                                     logic [bfpa_pkg::LEN_W-1:0] l);
    int i;
    int pos;
    if (tbl_used[m] < bfpa_pkg::MAX_EXTENTS) begin
      pos = tbl_used[m];
      for (i = tbl_used[m] - 1; i >= 0; i--) begin
        if (l <= tbl_len[m][i]) begin
          pos = i;
        end
      end
      for (i = tbl_used[m]; i > pos; i--) begin
        tbl_start[m][i] = tbl_start[m][i-1];
        tbl_len[m][i]   = tbl_len[m][i-1];
      end
      tbl_start[m][pos] = s;
      tbl_len[m][pos]   = l;
      tbl_used[m]++;
    end
  endfunction

  function automatic void tbl_credit(int m, logic [bfpa_pkg::LEN_W-1:0] n);
    longint total;
    total = longint'(tbl_free[m]) + longint'(n);
    if (total > longint'(bfpa_pkg::SUM_MAX)) begin
      total = longint'(bfpa_pkg::SUM_MAX);
    end
    tbl_free[m] = total[bfpa_pkg::LEN_W-1:0];
  endfunction

  function automatic logic [bfpa_pkg::ADDR_BITS-1:0] tbl_start_cast(longint v);
    return v[bfpa_pkg::ADDR_BITS-1:0];
  endfunction

  function automatic page_rsp_t allocator_step(int m, page_req_t r);
    page_rsp_t o;
    int        i;
    int        k;
    int        fit;
    int        lo;
    int        hi;
    longint    base;
    longint    n;
    longint    s;
    longint    l;
    longint    ms;
    longint    ml;
    longint    wrap_sum;
    o    = '0;
    k    = tbl_used[m];
    base = longint'(r.base_page);
    n    = longint'(r.page_count);
    case (r.opcode)
      bfpa_pkg::OP_ADD: begin
        if (n != 0) begin
          if (k >= bfpa_pkg::MAX_EXTENTS) begin
            o.status = bfpa_pkg::ST_FULL;
          end else begin
            tbl_insert(m, r.base_page, r.page_count);
            tbl_credit(m, r.page_count);
          end
        end
      end
      bfpa_pkg::OP_ALLOC: begin
        fit = -1;
        if (n == 0 || n > longint'(tbl_free[m])) begin
          o.status = bfpa_pkg::ST_NO_SPACE;
        end else begin
          for (i = 0; i < k && fit < 0; i++) begin
            if (longint'(tbl_len[m][i]) >= n) begin
              fit = i;
            end
          end
          if (fit < 0) begin
            o.status = bfpa_pkg::ST_NO_SPACE;
          end else begin
            s = longint'(tbl_start[m][fit]);
            l = longint'(tbl_len[m][fit]);
            tbl_remove(m, fit);
            if (l > n) begin
              wrap_sum = s + n;
              tbl_insert(m, wrap_sum[bfpa_pkg::ADDR_BITS-1:0], bfpa_pkg::LEN_W'(l - n));
            end
            o.alloc_base = tbl_start_cast(s);
            tbl_free[m]  = tbl_free[m] - r.page_count;
          end
        end
      end
      bfpa_pkg::OP_FREE: begin
        if (n != 0) begin
          lo = -1;
          hi = -1;
          ms = base;
          ml = n;
          for (i = 0; i < k && lo < 0; i++) begin
            if (longint'(tbl_start[m][i]) < base &&
                longint'(tbl_start[m][i]) + longint'(tbl_len[m][i]) == base) begin
              lo = i;
            end
          end
          if (lo >= 0) begin
            ms = longint'(tbl_start[m][lo]);
            ml = longint'(tbl_len[m][lo]) + n;
          end
          for (i = 0; i < k && hi < 0; i++) begin
            if (i != lo && longint'(tbl_start[m][i]) > ms &&
                ms + ml == longint'(tbl_start[m][i])) begin
              hi = i;
            end
          end
          if (hi >= 0) begin
            ml = ml + longint'(tbl_len[m][hi]);
          end
          if (lo < 0 && hi < 0 && k >= bfpa_pkg::MAX_EXTENTS) begin
            o.status = bfpa_pkg::ST_FULL;
          end else begin
            if (ml > longint'(bfpa_pkg::LEN_MAX)) begin
              ml = longint'(bfpa_pkg::LEN_MAX);
            end
            if (lo >= 0 && hi >= 0) begin
              tbl_remove(m, (lo > hi) ? lo : hi);
              tbl_remove(m, (lo > hi) ? hi : lo);
            end else if (lo >= 0) begin
              tbl_remove(m, lo);
            end else if (hi >= 0) begin
              tbl_remove(m, hi);
            end
            tbl_insert(m, ms[bfpa_pkg::ADDR_BITS-1:0], ml[bfpa_pkg::LEN_W-1:0]);
            tbl_credit(m, r.page_count);
          end
        end
      end
      default: begin
      end
    endcase
    o.free_total = tbl_free[m];
    return o;
  endfunction

  function automatic void queue_request(logic [1:0] op,
                                        logic [bfpa_pkg::ADDR_BITS-1:0] base,
                                        logic [bfpa_pkg::LEN_W-1:0] count);
    page_req_t item;
    page_rsp_t outcome;
    item.opcode     = op;
    item.base_page  = base;
    item.page_count = count;
    outcome = allocator_step(PLAN, item);
    if (op == bfpa_pkg::OP_ALLOC && outcome.status == bfpa_pkg::ST_OK) begin
      held_blocks.push_back({outcome.alloc_base, count});
    end
    pending_reqs.push_back(item);
    issued_count++;
    if (!(op == OP_SPARE || (count == 0 && op != bfpa_pkg::OP_ALLOC))) begin
      stim_count++;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at cycle %0d: got 0x%0h, want 0x%0h",
             what, cycle_count, got, want);
    err_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (checked_count != issued_count) begin
      @(negedge clk);
    end
  endtask

  task automatic run_random(int goal);
    int                             kind;
    int                             reps;
    int                             idx;
    int                             cut;
    logic [bfpa_pkg::ADDR_BITS-1:0] base;
    logic [bfpa_pkg::LEN_W-1:0]     count;
    logic [bfpa_pkg::LEN_W-1:0]     span;
    page_block_t                    blk;
    while (stim_count < goal) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          // carve a fresh region, then hand some blocks back
          base = bfpa_pkg::ADDR_BITS'($urandom_range(0, 32'hFEFFF));
          span = bfpa_pkg::LEN_W'($urandom_range(16, 512));
          queue_request(bfpa_pkg::OP_ADD, base, span);
          reps = $urandom_range(2, 6);
          repeat (reps) begin
            queue_request(bfpa_pkg::OP_ALLOC, '0,
                          bfpa_pkg::LEN_W'($urandom_range(1, span / 4)));
          end
          reps = (held_blocks.size() > 40) ? 24 : $urandom_range(0, 6);
          repeat (reps) begin
            if (held_blocks.size() != 0) begin
              idx = $urandom_range(0, held_blocks.size() - 1);
              blk = held_blocks[idx];
              held_blocks.delete(idx);
              queue_request(bfpa_pkg::OP_FREE, blk.base, blk.count);
            end
          end
        end
        4: begin
          // take whole extents to shrink the table
          reps = 0;
          while (tbl_used[PLAN] > 6 && reps < 12) begin
            idx = $urandom_range(0, tbl_used[PLAN] - 1);
            queue_request(bfpa_pkg::OP_ALLOC, '0, tbl_len[PLAN][idx]);
            reps++;
          end
        end
        5: begin
          repeat ($urandom_range(6, 12)) begin
            queue_request(bfpa_pkg::OP_ADD, bfpa_pkg::ADDR_BITS'($urandom()),
                          bfpa_pkg::LEN_W'($urandom_range(1, 64)));
          end
        end
        6: begin
          if (held_blocks.size() != 0) begin
            idx = $urandom_range(0, held_blocks.size() - 1);
            blk = held_blocks[idx];
            held_blocks.delete(idx);
            if (blk.count >= 2) begin
              cut = $urandom_range(1, blk.count - 1);
              if ($urandom_range(0, 1) == 0) begin
                queue_request(bfpa_pkg::OP_FREE, blk.base + bfpa_pkg::ADDR_BITS'(cut),
                              blk.count - bfpa_pkg::LEN_W'(cut));
                queue_request(bfpa_pkg::OP_FREE, blk.base, bfpa_pkg::LEN_W'(cut));
              end else begin
                queue_request(bfpa_pkg::OP_FREE, blk.base, bfpa_pkg::LEN_W'(cut));
                queue_request(bfpa_pkg::OP_FREE, blk.base + bfpa_pkg::ADDR_BITS'(cut),
                              blk.count - bfpa_pkg::LEN_W'(cut));
              end
            end else begin
              queue_request(bfpa_pkg::OP_FREE, blk.base, blk.count);
            end
          end
        end
        7: begin
          repeat ($urandom_range(4, 10)) begin
            case ($urandom_range(0, 3))
              0: count = '0;
              1: count = bfpa_pkg::LEN_W'($urandom());
              2: count = bfpa_pkg::LEN_W'($urandom_range(1, 64));
              default: count = bfpa_pkg::LEN_W'(1) << $urandom_range(0, bfpa_pkg::LEN_W - 1);
            endcase
            queue_request(2'($urandom_range(0, 3)), bfpa_pkg::ADDR_BITS'($urandom()), count);
          end
        end
        8: begin
          // free right next to an existing extent
          if (tbl_used[PLAN] != 0) begin
            idx   = $urandom_range(0, tbl_used[PLAN] - 1);
            count = bfpa_pkg::LEN_W'($urandom_range(1, 64));
            if ($urandom_range(0, 1) == 0) begin
              base = bfpa_pkg::ADDR_BITS'(tbl_start[PLAN][idx] + tbl_len[PLAN][idx]);
            end else begin
              base = tbl_start[PLAN][idx] - bfpa_pkg::ADDR_BITS'(count);
            end
            queue_request(bfpa_pkg::OP_FREE, base, count);
          end
        end
        default: begin
          case ($urandom_range(0, 2))
            0: queue_request(bfpa_pkg::OP_ADD, bfpa_pkg::ADDR_BITS'($urandom()),
                             bfpa_pkg::LEN_W'($urandom()));
            1: queue_request(bfpa_pkg::OP_ALLOC, bfpa_pkg::ADDR_BITS'($urandom()),
                             bfpa_pkg::LEN_W'($urandom_range(1, 32'h100000)));
            default: queue_request(bfpa_pkg::OP_ALLOC, '0, tbl_free[PLAN]);
          endcase
        end
      endcase
    end
  endtask

  // driver: advance to the next item once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_accepted) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        req_valid  <= 1'b1;
        req_opcode <= next_req.opcode;
        req_base   <= next_req.base_page;
        req_count  <= next_req.page_count;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !(hold_armed && hold_count < HOLD_CYCLES) &&
                   ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(negedge clk) begin
    if (hold_armed && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
    end
  end

  // monitor: check responses, then predict newly accepted items
  always @(posedge clk) begin
    cycle_count++;
    if (rst) begin
      req_accepted = 1'b0;
      tbl_clear(PRED);
    end else begin
      if (rsp.valid && rsp.ready) begin
        checked_count++;
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected response", rsp.status, 0);
        end else begin
          want_rsp = expected_rsps.pop_front();
          if (rsp.status !== want_rsp.status) begin
            report_mismatch("status", rsp.status, want_rsp.status);
          end
          if (rsp.alloc_base !== want_rsp.alloc_base) begin
            report_mismatch("alloc_base", rsp.alloc_base, want_rsp.alloc_base);
          end
          if (rsp.free_total !== want_rsp.free_total) begin
            report_mismatch("free_total", rsp.free_total, want_rsp.free_total);
          end
        end
      end
      req_accepted = req.valid && req.ready;
      if (req_accepted) begin
        seen_req.opcode     = req.opcode;
        seen_req.base_page  = req.base_page;
        seen_req.page_count = req.page_count;
        expected_rsps.push_back(allocator_step(PRED, seen_req));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int idle_plan [4];
    int stall_plan [4];
    int p;
    idle_plan  = '{0, 51, 0, 38};
    stall_plan = '{0, 0, 51, 38};
    tbl_clear(PLAN);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    queue_request(bfpa_pkg::OP_ALLOC, '0, bfpa_pkg::LEN_W'(1));
    queue_request(bfpa_pkg::OP_ADD, '0, '0);
    queue_request(bfpa_pkg::OP_ALLOC, '0, '0);
    queue_request(bfpa_pkg::OP_FREE, 20'h12345, '0);
    queue_request(OP_SPARE, 20'hFFFFF, bfpa_pkg::LEN_MAX);
    queue_request(bfpa_pkg::OP_ADD, 20'hFFFF0, 21'h100);
    queue_request(bfpa_pkg::OP_ALLOC, '0, 21'h20);
    queue_request(bfpa_pkg::OP_ADD, 20'h01000, 21'h10);
    queue_request(bfpa_pkg::OP_ADD, 20'h01020, 21'h10);
    queue_request(bfpa_pkg::OP_FREE, 20'h01010, 21'h10);
    queue_request(bfpa_pkg::OP_FREE, 20'h01030, 21'h8);
    queue_request(bfpa_pkg::OP_FREE, 20'h00FF8, 21'h8);
    queue_request(bfpa_pkg::OP_ALLOC, '0, 21'h100);
    queue_request(bfpa_pkg::OP_ALLOC, '0, 21'h200);
    queue_request(bfpa_pkg::OP_ALLOC, '0, 21'h40);
    queue_request(bfpa_pkg::OP_ADD, 20'h80000, bfpa_pkg::LEN_MAX);
    queue_request(bfpa_pkg::OP_FREE, 20'h40000, 21'h40000);
    queue_request(bfpa_pkg::OP_ALLOC, '0, bfpa_pkg::SUM_MAX);
    queue_request(bfpa_pkg::OP_ALLOC, '0, bfpa_pkg::LEN_W'(1));
    queue_request(bfpa_pkg::OP_FREE, 20'hFFFFF, bfpa_pkg::LEN_W'(1));
    queue_request(bfpa_pkg::OP_ALLOC, 20'hFFFFF, bfpa_pkg::LEN_W'(1));
    wait_drained();

    for (p = 0; p < 4; p++) begin
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      run_random(stim_count + 205);
      wait_drained();
    end

    // hold the receiver off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_armed     = 1'b1;
    run_random(stim_count + 55);
    wait_drained();

    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/bfpa_pkg.sv
hdl/bfpa_req_if.sv
hdl/bfpa_rsp_if.sv
hdl/bfpa_cell.sv
hdl/bfpa_chain.sv
hdl/best_fit_page_allocator.sv
dv/best_fit_page_allocator_tb.sv
